FILE: hw/rtl/erd_pkg.sv
package erd_pkg;

  localparam int MAX_PREFIX_BYTES = 4;
  localparam int BODY_BYTES       = 23;
  localparam int HDR_BYTES        = 22;
  localparam int HDR_STORE        = HDR_BYTES - 1;
  localparam int LEN_W            = 28;
  localparam int REC_W            = 29;
  localparam int IDX_W            = 5;
  localparam int CNT_W            = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 8;
  localparam logic [7:0] LOW7_MASK = 8'h7f;
  localparam logic [7:0] CONT_BIT  = 8'h80;
  localparam logic [31:0] P1_MAX   = 32'd127;

  typedef enum logic [2:0] {
    KIND_HEADER      = 3'd0,
    KIND_PAYLOAD     = 3'd1,
    KIND_BAD_CLASS   = 3'd2,
    KIND_SHORT       = 3'd3,
    KIND_PREFIX_LONG = 3'd4
  } erd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREFIXED_MODE = 3'd0,
    REG_SYSEX_TYPE    = 3'd1,
    REG_META_TYPE     = 3'd2,
    REG_NOTE_TYPE     = 3'd3,
    REG_NOTE_OFF_TYPE = 3'd4
  } erd_reg_t;

  typedef struct packed {
    logic       prefixed_mode;
    logic [7:0] sysex_type_code;
    logic [7:0] meta_generic_type_code;
    logic [7:0] note_type_code;
    logic [7:0] note_off_type_code;
  } erd_cfg_t;

  typedef struct packed {
    erd_kind_t          result_kind;
    logic [7:0]         event_type;
    logic [7:0]         channel_number;
    logic [31:0]        tick_time;
    logic [31:0]        length_word;
    logic signed [31:0] first_param;
    logic signed [31:0] second_param;
    logic signed [31:0] third_param;
    logic [7:0]         payload_byte;
    logic [REC_W-1:0]   record_bytes;
    logic               last_of_record;
  } erd_result_t;

endpackage

FILE: hw/rtl/erd_stream_if.sv
interface erd_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

FILE: hw/rtl/erd_result_if.sv
interface erd_result_if;
  import erd_pkg::*;

  logic                 valid;
  logic                 ready;
  erd_kind_t            result_kind;
  logic [7:0]           event_type;
  logic [7:0]           channel_number;
  logic [31:0]          tick_time;
  logic [31:0]          length_word;
  logic signed [31:0]   first_param;
  logic signed [31:0]   second_param;
  logic signed [31:0]   third_param;
  logic [7:0]           payload_byte;
  logic [REC_W-1:0]     record_bytes;
  logic                 last_of_record;

  modport source (
    output valid, output result_kind, output event_type, output channel_number,
    output tick_time, output length_word, output first_param, output second_param,
    output third_param, output payload_byte, output record_bytes, output last_of_record,
    input ready
  );
  modport sink (
    input valid, input result_kind, input event_type, input channel_number,
    input tick_time, input length_word, input first_param, input second_param,
    input third_param, input payload_byte, input record_bytes, input last_of_record,
    output ready
  );
endinterface

FILE: hw/rtl/erd_cfg_if.sv
interface erd_cfg_if;
  import erd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/event_record_decoder_top.sv
// A result word is registered and is valid in the cycle after the stream word that causes it is accepted.
// Throughput: one stream word per cycle unless the output stalls; the parse state updates on every accepted word.
// Stream ready drops only while a finished result waits at the output register.
// Reset (rst, synchronous, active high) returns to the record-start state, clears
// counters and the output valid, and loads the default type codes, prefixed mode on.
module event_record_decoder_top (
  input  logic         clk,
  input  logic         rst,
  erd_cfg_if.sink      cfg,
  erd_stream_if.sink   stream,
  erd_result_if.source result
);
  import erd_pkg::*;

  erd_cfg_t    regs;
  erd_result_t res;
  logic        res_valid;
  logic        can_take;
  logic        accept;

  assign stream.ready = can_take;
  assign accept       = stream.valid && can_take;

  erd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  erd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (stream.stream_byte),
    .regs        (regs),
    .res_valid   (res_valid),
    .res         (res)
  );

  erd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && res_valid),
    .res      (res),
    .can_take (can_take),
    .result   (result)
  );

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == KIND_BAD_CLASS ||
                     result.result_kind == KIND_SHORT ||
                     result.result_kind == KIND_PREFIX_LONG) |-> result.last_of_record)
    else $error("error result not marked last");

  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind == KIND_HEADER |->
      result.record_bytes >= REC_W'(BODY_BYTES))
    else $error("header record length below body size");

  a_payload_only: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind != KIND_PAYLOAD |-> result.payload_byte == 8'd0)
    else $error("payload byte set on non-payload result");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !stream.ready)
    else $error("stream accepted while result stalled");

endmodule

FILE: hw/rtl/erd_cfg_regs.sv
module erd_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  erd_cfg_if.sink          cfg,
  output erd_pkg::erd_cfg_t regs
);
  import erd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prefixed_mode          <= 1'b1;
      regs.sysex_type_code        <= 8'd0;
      regs.meta_generic_type_code <= 8'd1;
      regs.note_type_code         <= 8'd2;
      regs.note_off_type_code     <= 8'd3;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PREFIXED_MODE: regs.prefixed_mode          <= cfg.data[0];
        REG_SYSEX_TYPE:    regs.sysex_type_code        <= cfg.data;
        REG_META_TYPE:     regs.meta_generic_type_code <= cfg.data;
        REG_NOTE_TYPE:     regs.note_type_code         <= cfg.data;
        REG_NOTE_OFF_TYPE: regs.note_off_type_code     <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/erd_parser.sv
module erd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           stream_byte,
  input  erd_pkg::erd_cfg_t    regs,
  output logic                 res_valid,
  output erd_pkg::erd_result_t res
);
  import erd_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_PREFIX, PH_CLASS, PH_HEADER, PH_PAYLOAD, PH_SKIP, PH_DRAIN
  } phase_t;

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   prefix_value, prefix_value_next;
  logic [CNT_W-1:0]   prefix_count, prefix_count_next;
  logic [IDX_W-1:0]   hdr_idx, hdr_idx_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic [7:0]         hdr [HDR_STORE];

  logic [LEN_W-1:0]   cur_pv, cur_bl, pv_shift, bl_dec;
  logic [CNT_W-1:0]   cur_pc, pc_inc;
  logic [IDX_W-1:0]   idx_sel, idx_inc;
  logic               do_prefix, do_class, hdr_we;
  logic [7:0]         type_b;
  logic [31:0]        p1_raw, p1_clamped;
  logic               is_note, varlen;

  assign cur_pv   = (phase == PH_START) ? '0 : prefix_value;
  assign cur_pc   = (phase == PH_START) ? '0 : prefix_count;
  assign cur_bl   = (phase == PH_START) ? '0 : bytes_left;
  assign pv_shift = {cur_pv[LEN_W-8:0], stream_byte[6:0] & LOW7_MASK[6:0]};
  assign pc_inc   = cur_pc + CNT_W'(1);
  assign bl_dec   = (cur_bl == '0) ? '0 : cur_bl - LEN_W'(1);
  assign idx_sel  = (hdr_idx >= IDX_W'(HDR_STORE)) ? IDX_W'(HDR_STORE) : hdr_idx;
  assign idx_inc  = idx_sel + IDX_W'(1);
  assign do_prefix = ((phase == PH_START) && regs.prefixed_mode) || (phase == PH_PREFIX);
  assign do_class  = ((phase == PH_START) && !regs.prefixed_mode) || (phase == PH_CLASS);
  assign hdr_we    = accept && (phase == PH_HEADER) && (idx_sel != IDX_W'(HDR_STORE));

  assign type_b  = hdr[0];
  assign p1_raw  = {hdr[13], hdr[12], hdr[11], hdr[10]};
  assign is_note = (type_b == regs.note_type_code) || (type_b == regs.note_off_type_code);
  assign varlen  = (type_b == regs.sysex_type_code) || (type_b == regs.meta_generic_type_code);

  always_comb begin
    p1_clamped = p1_raw;
    if (is_note) begin
      if (p1_raw[31]) begin
        p1_clamped = '0;
      end else if (p1_raw > P1_MAX) begin
        p1_clamped = P1_MAX;
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    prefix_value_next = cur_pv;
    prefix_count_next = cur_pc;
    bytes_left_next   = cur_bl;
    hdr_idx_next      = hdr_idx;
    res_valid         = 1'b0;
    res               = '0;
    res.result_kind   = KIND_HEADER;

    if (do_prefix) begin
      prefix_value_next = pv_shift;
      prefix_count_next = pc_inc;
      if ((stream_byte & CONT_BIT) != 8'd0) begin
        if (pc_inc >= CNT_W'(MAX_PREFIX_BYTES)) begin
          phase_next         = PH_DRAIN;
          res_valid          = 1'b1;
          res.result_kind    = KIND_PREFIX_LONG;
          res.last_of_record = 1'b1;
        end else begin
          phase_next = PH_PREFIX;
        end
      end else begin
        bytes_left_next = pv_shift;
        if (pv_shift < LEN_W'(BODY_BYTES)) begin
          phase_next         = (pv_shift != '0) ? PH_SKIP : PH_START;
          res_valid          = 1'b1;
          res.result_kind    = KIND_SHORT;
          res.last_of_record = 1'b1;
        end else begin
          phase_next = PH_CLASS;
        end
      end
    end else if (do_class) begin
      bytes_left_next = bl_dec;
      if (stream_byte != 8'd0) begin
        phase_next         = (bl_dec != '0) ? PH_SKIP : PH_START;
        res_valid          = 1'b1;
        res.result_kind    = KIND_BAD_CLASS;
        res.last_of_record = 1'b1;
      end else begin
        hdr_idx_next = '0;
        phase_next   = PH_HEADER;
      end
    end else begin
      case (phase)
        PH_HEADER: begin
          hdr_idx_next    = idx_inc;
          bytes_left_next = bl_dec;
          if (idx_inc >= IDX_W'(HDR_BYTES)) begin
            res_valid          = 1'b1;
            res.result_kind    = KIND_HEADER;
            res.event_type     = type_b;
            res.channel_number = hdr[1];
            res.tick_time      = {hdr[5], hdr[4], hdr[3], hdr[2]};
            res.length_word    = {hdr[9], hdr[8], hdr[7], hdr[6]};
            res.first_param    = p1_clamped;
            res.second_param   = {hdr[17], hdr[16], hdr[15], hdr[14]};
            res.third_param    = {stream_byte, hdr[20], hdr[19], hdr[18]};
            res.record_bytes   = (cur_pc != '0) ?
                                 ({1'b0, cur_pv} + REC_W'(cur_pc)) : REC_W'(BODY_BYTES);
            if (varlen && (bl_dec != '0)) begin
              phase_next = PH_PAYLOAD;
            end else begin
              phase_next         = (bl_dec != '0) ? PH_SKIP : PH_START;
              res.last_of_record = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next    = bl_dec;
          res_valid          = 1'b1;
          res.result_kind    = KIND_PAYLOAD;
          res.payload_byte   = stream_byte;
          res.last_of_record = (bl_dec == '0);
          if (bl_dec == '0) begin
            phase_next = PH_START;
          end
        end
        PH_SKIP: begin
          bytes_left_next = bl_dec;
          if (bl_dec == '0) begin
            phase_next = PH_START;
          end
        end
        PH_DRAIN: begin
          if ((stream_byte & CONT_BIT) == 8'd0) begin
            phase_next = PH_START;
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      prefix_value <= '0;
      prefix_count <= '0;
      hdr_idx      <= '0;
      bytes_left   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      prefix_value <= prefix_value_next;
      prefix_count <= prefix_count_next;
      hdr_idx      <= hdr_idx_next;
      bytes_left   <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr[idx_sel] <= stream_byte;
    end
  end

endmodule

FILE: hw/rtl/erd_out_stage.sv
module erd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  erd_pkg::erd_result_t res,
  output logic                 can_take,
  erd_result_if.source         result
);
  import erd_pkg::*;

  logic        valid;
  erd_result_t data;

  assign can_take = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign result.valid          = valid;
  assign result.result_kind    = data.result_kind;
  assign result.event_type     = data.event_type;
  assign result.channel_number = data.channel_number;
  assign result.tick_time      = data.tick_time;
  assign result.length_word    = data.length_word;
  assign result.first_param    = data.first_param;
  assign result.second_param   = data.second_param;
  assign result.third_param    = data.third_param;
  assign result.payload_byte   = data.payload_byte;
  assign result.record_bytes   = data.record_bytes;
  assign result.last_of_record = data.last_of_record;

endmodule

FILE: tb/erd_record_checker.sv
`timescale 1ns / 1ps
module erd_record_checker #(
  parameter erd_pkg::erd_cfg_t RESET_REGS = '0
) (
  input  logic  clk,
  input  logic  rst,
  erd_cfg_if    cfg,
  erd_stream_if stream,
  erd_result_if result,
  output int    errors,
  output int    pending
);
  import erd_pkg::*;

  typedef enum logic [2:0] {
    AT_RECORD, IN_SIZE, AT_CLASS, IN_HEADER, IN_PAYLOAD, IN_SKIP, IN_DRAIN
  } parse_step_t;

  erd_cfg_t         regs;
  parse_step_t      step;
  logic [LEN_W-1:0] size_acc;
  logic [LEN_W-1:0] body_left;
  logic [CNT_W-1:0] size_bytes;
  logic [IDX_W-1:0] hdr_pos;
  logic [7:0]       hdr [HDR_BYTES];
  erd_result_t      expected_q [$];

  function automatic erd_result_t flag(input erd_kind_t kind);
    erd_result_t r;
    r = '0;
    r.result_kind = kind;
    r.last_of_record = 1'b1;
    return r;
  endfunction

  function automatic void consume_body();
    if (body_left != 0) body_left = body_left - 1'b1;
  endfunction

  function automatic void finish_record();
    step = (body_left != 0) ? IN_SKIP : AT_RECORD;
  endfunction

  function automatic logic [31:0] hdr_word(input int base);
    return {hdr[base + 3], hdr[base + 2], hdr[base + 1], hdr[base]};
  endfunction

  function automatic bit size_word(input logic [7:0] b, output erd_result_t r);
    r = '0;
    size_acc = {size_acc[LEN_W-8:0], b[6:0]};
    size_bytes = size_bytes + 1'b1;
    if (b[7]) begin
      if (size_bytes >= MAX_PREFIX_BYTES) begin
        step = IN_DRAIN;
        r = flag(KIND_PREFIX_LONG);
        return 1'b1;
      end
      step = IN_SIZE;
      return 1'b0;
    end
    body_left = size_acc;
    if (size_acc < BODY_BYTES) begin
      finish_record();
      r = flag(KIND_SHORT);
      return 1'b1;
    end
    step = AT_CLASS;
    return 1'b0;
  endfunction

  function automatic bit class_word(input logic [7:0] b, output erd_result_t r);
    r = '0;
    consume_body();
    if (b != 8'h00) begin
      finish_record();
      r = flag(KIND_BAD_CLASS);
      return 1'b1;
    end
    hdr_pos = '0;
    foreach (hdr[i]) hdr[i] = 8'h00;
    step = IN_HEADER;
    return 1'b0;
  endfunction

  function automatic bit header_word(input logic [7:0] b, output erd_result_t r);
    logic [31:0] p1;
    logic [7:0]  kind_code;
    r = '0;
    hdr[hdr_pos] = b;
    hdr_pos = hdr_pos + 1'b1;
    consume_body();
    if (hdr_pos < HDR_BYTES) return 1'b0;
    kind_code = hdr[0];
    p1 = hdr_word(10);
    if (kind_code == regs.note_type_code || kind_code == regs.note_off_type_code) begin
      if (p1[31]) p1 = '0;
      else if (p1 > P1_MAX) p1 = P1_MAX;
    end
    r.result_kind    = KIND_HEADER;
    r.event_type     = kind_code;
    r.channel_number = hdr[1];
    r.tick_time      = hdr_word(2);
    r.length_word    = hdr_word(6);
    r.first_param    = p1;
    r.second_param   = hdr_word(14);
    r.third_param    = hdr_word(18);
    r.record_bytes   = (size_bytes != 0) ? REC_W'(size_bytes) + REC_W'(size_acc)
                                         : REC_W'(BODY_BYTES);
    if ((kind_code == regs.sysex_type_code || kind_code == regs.meta_generic_type_code)
        && body_left != 0) begin
      step = IN_PAYLOAD;
      r.last_of_record = 1'b0;
    end else begin
      finish_record();
      r.last_of_record = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic bit decode_word(input logic [7:0] b, output erd_result_t r);
    r = '0;
    case (step)
      AT_RECORD: begin
        size_acc = '0;
        size_bytes = '0;
        body_left = '0;
        if (regs.prefixed_mode) return size_word(b, r);
        return class_word(b, r);
      end
      IN_SIZE:   return size_word(b, r);
      AT_CLASS:  return class_word(b, r);
      IN_HEADER: return header_word(b, r);
      IN_PAYLOAD: begin
        consume_body();
        r.result_kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.last_of_record = (body_left == 0);
        if (body_left == 0) step = AT_RECORD;
        return 1'b1;
      end
      IN_SKIP: begin
        consume_body();
        if (body_left == 0) step = AT_RECORD;
        return 1'b0;
      end
      IN_DRAIN: begin
        if (!b[7]) step = AT_RECORD;
        return 1'b0;
      end
      default: begin
        step = AT_RECORD;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, seen);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    erd_result_t want, got;
    if (rst) begin
      regs = RESET_REGS;
      step = AT_RECORD;
      size_acc = '0;
      size_bytes = '0;
      body_left = '0;
      hdr_pos = '0;
      foreach (hdr[i]) hdr[i] = 8'h00;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PREFIXED_MODE: regs.prefixed_mode = cfg.data[0];
          REG_SYSEX_TYPE:    regs.sysex_type_code = cfg.data;
          REG_META_TYPE:     regs.meta_generic_type_code = cfg.data;
          REG_NOTE_TYPE:     regs.note_type_code = cfg.data;
          REG_NOTE_OFF_TYPE: regs.note_off_type_code = cfg.data;
          default: ;
        endcase
      end
      if (stream.valid && stream.ready) begin
        if (decode_word(stream.stream_byte, want)) expected_q.insert(expected_q.size(), want);
      end
      if (result.valid && result.ready) begin
        got.result_kind    = result.result_kind;
        got.event_type     = result.event_type;
        got.channel_number = result.channel_number;
        got.tick_time      = result.tick_time;
        got.length_word    = result.length_word;
        got.first_param    = result.first_param;
        got.second_param   = result.second_param;
        got.third_param    = result.third_param;
        got.payload_byte   = result.payload_byte;
        got.record_bytes   = result.record_bytes;
        got.last_of_record = result.last_of_record;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word expected none actual %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", want.result_kind, got.result_kind);
          check_field("event_type", want.event_type, got.event_type);
          check_field("channel_number", want.channel_number, got.channel_number);
          check_field("tick_time", want.tick_time, got.tick_time);
          check_field("length_word", want.length_word, got.length_word);
          check_field("first_param", want.first_param, got.first_param);
          check_field("second_param", want.second_param, got.second_param);
          check_field("third_param", want.third_param, got.third_param);
          check_field("payload_byte", want.payload_byte, got.payload_byte);
          check_field("record_bytes", want.record_bytes, got.record_bytes);
          check_field("last_of_record", want.last_of_record, got.last_of_record);
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import erd_pkg::*;

  localparam erd_cfg_t RESET_REGS   = '{1'b1, 8'h00, 8'h01, 8'h02, 8'h03};
  localparam int       STALL_LIMIT  = 2000;
  localparam int       RANDOM_BYTES = 480;
  localparam int       PHASES       = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;
  int   waiting;
  int   quiet;
  int   idle_pct;
  int   stall_pct;

  erd_cfg_t   regs_now;
  logic [7:0] byte_q [$];
  logic [7:0] held_q [$];

  erd_cfg_if    cfg ();
  erd_stream_if stream ();
  erd_result_if result ();

  event_record_decoder_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stream (stream),
    .result (result)
  );

  erd_record_checker #(.RESET_REGS(RESET_REGS)) record_check (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .stream  (stream),
    .result  (result),
    .errors  (fails),
    .pending (waiting)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    result.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (stream.valid && stream.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pick_param();
    case ($urandom_range(9))
      0: return 32'd127;
      1: return 32'd128;
      2: return 32'hffffffff;
      3: return 32'h80000000;
      4: return 32'h7fffffff;
      5: return 32'd0;
      6: return 32'($urandom_range(255));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(4))
      0: return regs_now.sysex_type_code;
      1: return regs_now.meta_generic_type_code;
      2: return regs_now.note_type_code;
      3: return regs_now.note_off_type_code;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    byte_q.insert(byte_q.size(), b);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endtask

  // size prefix, most significant group first, sometimes with a leading empty group
  task automatic put_size(input int unsigned v);
    int n;
    n = 1;
    while (n < MAX_PREFIX_BYTES && (v >> (7 * n)) != 0) n++;
    if (n < MAX_PREFIX_BYTES && $urandom_range(3) == 0) n++;
    for (int k = n - 1; k >= 0; k--) begin
      add_byte((8'(v >> (7 * k)) & LOW7_MASK) | ((k != 0) ? CONT_BIT : 8'h00));
    end
  endtask

  task automatic put_record(input bit pre, input logic [7:0] cls, input logic [7:0] kind,
                            input logic [7:0] chan, input logic [31:0] tick,
                            input logic [31:0] len, input logic [31:0] p1,
                            input logic [31:0] p2, input logic [31:0] p3, input int extra);
    if (pre) put_size(BODY_BYTES + extra);
    add_byte(cls);
    add_byte(kind);
    add_byte(chan);
    put_word(tick);
    put_word(len);
    put_word(p1);
    put_word(p2);
    put_word(p3);
    if (pre) repeat (extra) add_byte(8'($urandom()));
  endtask

  task automatic put_sized_junk(input int v);
    put_size(v);
    repeat (v) add_byte(8'($urandom()));
  endtask

  task automatic put_overlong_size();
    repeat (MAX_PREFIX_BYTES) add_byte(8'($urandom()) | CONT_BIT);
    repeat ($urandom_range(3)) add_byte(8'($urandom()) | CONT_BIT);
    add_byte(8'($urandom()) & LOW7_MASK);
  endtask

  task automatic put_random_record();
    int  sel;
    int  extra;
    bit  pre;
    pre = regs_now.prefixed_mode;
    sel = $urandom_range(99);
    extra = ($urandom_range(29) == 0) ? $urandom_range(240, 300) : $urandom_range(12);
    if (sel < 70 || (!pre && sel >= 78 && sel < 91)) begin
      put_record(pre, 8'h00, pick_type(), 8'($urandom()), $urandom(), $urandom(),
                 pick_param(), pick_param(), pick_param(), extra);
    end else if (sel < 78) begin
      if (pre) begin
        put_record(1'b1, 8'($urandom_range(1, 255)), pick_type(), 8'($urandom()),
                   $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), extra);
      end else begin
        add_byte(8'($urandom_range(1, 255)));
      end
    end else if (sel < 86) begin
      put_sized_junk($urandom_range(0, BODY_BYTES - 1));
    end else if (sel < 91) begin
      put_overlong_size();
    end else if (pre) begin
      put_sized_junk($urandom_range(BODY_BYTES, 60));
    end else begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom()));
    end
  endtask

  task automatic send_stream();
    while (byte_q.size() > 0) begin
      if ($urandom_range(99) < idle_pct) begin
        stream.valid <= 1'b0;
        @(posedge clk);
      end else begin
        stream.valid <= 1'b1;
        stream.stream_byte <= byte_q[0];
        do @(posedge clk); while (!stream.ready);
        void'(byte_q.pop_front());
      end
    end
    stream.valid <= 1'b0;
  endtask

  task automatic put_reg(input erd_reg_t idx, input logic [7:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic write_regs(input erd_cfg_t c);
    put_reg(REG_PREFIXED_MODE, {7'd0, c.prefixed_mode});
    put_reg(REG_SYSEX_TYPE, c.sysex_type_code);
    put_reg(REG_META_TYPE, c.meta_generic_type_code);
    put_reg(REG_NOTE_TYPE, c.note_type_code);
    put_reg(REG_NOTE_OFF_TYPE, c.note_off_type_code);
    cfg.valid <= 1'b0;
    regs_now = c;
  endtask

  task automatic settle();
    repeat (2) @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    erd_cfg_t c;
    cfg.valid          <= 1'b0;
    cfg.index          <= REG_PREFIXED_MODE;
    cfg.data           <= 8'h00;
    stream.valid       <= 1'b0;
    stream.stream_byte <= 8'h00;
    idle_pct  = 0;
    stall_pct = 0;
    regs_now  = RESET_REGS;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: prefixed records
    put_record(1'b1, 8'h00, regs_now.note_type_code, 8'h01, 32'd10, 32'd0,
               32'd200, 32'd5, 32'd6, 0);
    put_record(1'b1, 8'h00, regs_now.note_off_type_code, 8'h02, 32'd11, 32'd0,
               32'hfffffffb, 32'd0, 32'd0, 0);
    put_record(1'b1, 8'h00, regs_now.note_type_code, 8'h00, 32'd0, 32'd0,
               32'd127, 32'd0, 32'd0, 1);
    put_record(1'b1, 8'h00, regs_now.note_off_type_code, 8'h00, 32'd0, 32'd0,
               32'd128, 32'd0, 32'd0, 0);
    put_record(1'b1, 8'h00, regs_now.sysex_type_code, 8'h7f, 32'd1, 32'd3,
               32'd1000, 32'd0, 32'd0, 3);
    put_record(1'b1, 8'h00, regs_now.meta_generic_type_code, 8'h80, 32'd2, 32'd0,
               32'd1, 32'd2, 32'd3, 0);
    put_record(1'b1, 8'h00, 8'hff, 8'hff, 32'hffffffff, 32'd0,
               32'h80000000, 32'h7fffffff, 32'h80000000, 2);
    put_record(1'b1, 8'hff, 8'h00, 8'h00, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 7);
    put_sized_junk(5);
    put_sized_junk(0);
    put_overlong_size();
    put_record(1'b1, 8'h00, 8'h22, 8'h05, 32'd7, 32'd8, 32'd9, 32'd10, 32'd11, 0);
    put_record(1'b1, 8'h00, regs_now.sysex_type_code, 8'h03, 32'd4, 32'd260,
               32'd0, 32'd0, 32'd0, 260);
    // mode change while the tail of a record is still to be skipped
    put_record(1'b1, 8'h00, 8'h40, 8'h09, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 4);
    repeat (4) held_q.push_front(byte_q.pop_back());
    send_stream();
    settle();

    c = RESET_REGS;
    c.prefixed_mode = 1'b0;
    write_regs(c);
    byte_q = held_q;
    put_record(1'b0, 8'h00, regs_now.note_type_code, 8'h0a, 32'd3, 32'd0,
               32'hffffffff, 32'd1, 32'd2, 0);
    put_record(1'b0, 8'h00, regs_now.sysex_type_code, 8'h0b, 32'd3, 32'd99,
               32'd1, 32'd1, 32'd1, 0);
    add_byte(8'h01);
    put_record(1'b0, 8'h00, regs_now.meta_generic_type_code, 8'h0c, 32'd5, 32'd0,
               32'd300, 32'd0, 32'd0, 0);
    send_stream();
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: c = '{1'b1, 8'hff, 8'h00, 8'hff, 8'h00};
        1: c = '{1'b0, 8'h00, 8'hff, 8'h00, 8'hff};
        default: c = '{1'($urandom_range(1)), 8'($urandom()), 8'($urandom()),
                       8'($urandom()), 8'($urandom())};
      endcase
      if (p == PHASES - 1) c.prefixed_mode = 1'b1;
      write_regs(c);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      while (byte_q.size() < RANDOM_BYTES / PHASES) put_random_record();
      if (p == PHASES - 1) begin
        // largest size the prefix can carry; the run ends inside its payload
        repeat (MAX_PREFIX_BYTES - 1) add_byte(8'hff);
        add_byte(LOW7_MASK);
        put_record(1'b0, 8'h00, regs_now.sysex_type_code, 8'h55, $urandom(), $urandom(),
                   pick_param(), pick_param(), pick_param(), 0);
        repeat (6) add_byte(8'($urandom()));
      end
      send_stream();
      settle();
    end

    if (fails == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: event_record_decoder_top.f
hw/rtl/erd_pkg.sv
hw/rtl/erd_stream_if.sv
hw/rtl/erd_result_if.sv
hw/rtl/erd_cfg_if.sv
hw/rtl/erd_cfg_regs.sv
hw/rtl/erd_parser.sv
hw/rtl/erd_out_stage.sv
hw/rtl/event_record_decoder_top.sv
tb/erd_record_checker.sv
tb/testbench.sv
